/* rtl/dscl_pkg.sv */
// Package for the sectored cache directory: sizes, address split widths, state and
// result kind types, the directory row and the compare request. No dependencies.
`default_nettype none
package dscl_pkg;
   localparam int NumSets         = 16;
   localparam int SectorsPerSet   = 4;
   localparam int BlocksPerSector = 4;
   localparam int TagsPerSector   = 2;
   localparam int BlockBytes      = 32;

   localparam int OffW   = $clog2(BlockBytes);
   localparam int BlkW   = (BlocksPerSector > 1) ? $clog2(BlocksPerSector) : 1;
   localparam int SetW   = (NumSets > 1) ? $clog2(NumSets) : 1;
   localparam int SlotW  = (TagsPerSector > 1) ? $clog2(TagsPerSector) : 1;
   localparam int SecW   = (SectorsPerSet > 1) ? $clog2(SectorsPerSet) : 1;
   localparam int BlkB   = $clog2(BlocksPerSector);
   localparam int SetB   = $clog2(NumSets);
   localparam int SlotB  = $clog2(TagsPerSector);
   localparam int TagW   = 32 - OffW - BlkB - SetB - SlotB;
   localparam int NSect  = NumSets * SectorsPerSet;
   localparam int SxW    = $clog2(NSect);

   typedef enum logic [1:0] {
      KIND_HIT  = 2'd0,
      KIND_WB   = 2'd1,
      KIND_FILL = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SCAN, ST_EMIT, ST_LOAD, ST_BLOCKS, ST_FILL
   } state_type;

   // One sector's directory row.
   typedef struct packed {
      logic [TagsPerSector-1:0][TagW-1:0]      tag_value;
      logic [TagsPerSector-1:0]                tag_live;
      logic [BlocksPerSector-1:0]              blk_live;
      logic [BlocksPerSector-1:0]              blk_mod;
      logic [BlocksPerSector-1:0][SlotW-1:0]   blk_slot;
   } row_type;

   // Compare unit request.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } cmp_req_type;
endpackage
`default_nettype wire

/* rtl/dscl_cmp.sv */
// Shared compare unit: unsigned less-than, one pair per cycle.
// Depends on dscl_pkg.
`default_nettype none
module dscl_cmp
   import dscl_pkg::*;
(
   input  wire cmp_req_type req,
   output logic             less
);
   assign less = req.a < req.b;
endmodule
`default_nettype wire

/* rtl/decoupled_sectored_cache_lookup.sv */
// Sectored cache directory lookup, one access at a time.
// A hit gives one result; a miss gives the writebacks of the victim's displaced dirty
// blocks and then the fill. A result waits on rsp_tready. Each sector costs a registered
// row read and a pass through the shared compare unit; the victim sweep takes one block a
// cycle while no writeback waits on rsp_tready. req_tready is low until the access is done.
// Reset clears the state, the stamp counter, the output valid and one valid bit per row;
// an unwritten row reads as all zero, so no clearing pass. Depends on dscl_pkg and dscl_cmp.
`default_nettype none
module decoupled_sectored_cache_lookup
   import dscl_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // [0] cmd, [32:1] address, zero fill
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] kind, [33:2] mem_address, [34] hit
   output logic        rsp_tlast
);
   // Directory storage; rows indexed by set*sectors+sector.
   row_type     rows_ff [NSect];
   logic [31:0] stamp_ff [NSect];
   logic [NSect-1:0] row_ok_ff;   // row written since reset
   logic [31:0] counter_ff, counter_in;

   state_type   state_ff, state_in;
   logic        wr_ff;
   logic [31:0] addr_ff;
   logic [SecW-1:0] sec_ff;     // scan index
   logic [BlkW-1:0] bi_ff;      // block sweep index
   logic        found_ff, ib_ff, it_ff;
   logic [SecW-1:0] lru_ff, vb_ff, vt_ff, victim_ff;
   logic [31:0] lru_stamp_ff;
   logic [1:0]  okind_ff;
   logic [31:0] oaddr_ff;
   logic        ohit_ff, olast_ff;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   row_type     vrow_ff;

   // Registered read port of the row and stamp memories.
   row_type     rd_row_ff;
   logic [31:0] rd_stamp_ff;
   logic        rd_ok_ff;

   // Address split.
   logic [BlkW-1:0]  a_blk;
   logic [SetW-1:0]  a_set;
   logic [SlotW-1:0] a_slot;
   logic [TagW-1:0]  a_tag;
   logic [31:0]      bnum;
   always_comb begin
      bnum   = addr_ff >> OffW;
      a_blk  = (BlkB  > 0) ? BlkW'(bnum[BlkW-1:0]) : '0;
      a_set  = (SetB  > 0) ? SetW'(bnum >> BlkB) : '0;
      a_slot = (SlotB > 0) ? SlotW'(bnum >> (BlkB + SetB)) : '0;
      a_tag  = TagW'(bnum >> (BlkB + SetB + SlotB));
   end

   function automatic logic [SxW-1:0] sx_of(logic [SetW-1:0] st, logic [SecW-1:0] sc);
      logic [31:0] v;
      v = 32'(st) * 32'(SectorsPerSet) + 32'(sc);
      return SxW'(v);
   endfunction

   // Read address: the scanned sector, or the chosen victim once the scan is done.
   logic [SecW-1:0] victim_sel;
   logic [SxW-1:0]  rd_sx;
   always_comb begin
      victim_sel = ib_ff ? vb_ff : (it_ff ? vt_ff : lru_ff);
      rd_sx      = (state_ff == ST_EMIT) ? sx_of(a_set, victim_sel) : sx_of(a_set, sec_ff);
   end

   // Scan-stage view of the current sector; an unwritten row reads as zero.
   logic [SxW-1:0] cur_sx;
   row_type        cur_row;
   logic [31:0]    cur_stamp_rd;
   logic           tmatch, blive, hitcond;
   always_comb begin
      cur_sx       = sx_of(a_set, sec_ff);
      cur_row      = rd_ok_ff ? rd_row_ff : '0;
      cur_stamp_rd = rd_ok_ff ? rd_stamp_ff : '0;
      tmatch  = cur_row.tag_live[a_slot] && (cur_row.tag_value[a_slot] == a_tag);
      blive   = cur_row.blk_live[a_blk];
      hitcond = tmatch && blive && (cur_row.blk_slot[a_blk] == a_slot);
   end

   // Shared compare: stamp vs current LRU stamp during scan.
   cmp_req_type cmp_req;
   logic        cmp_less;
   logic [31:0] cur_stamp;
   assign cur_stamp = hitcond ? counter_ff : cur_stamp_rd;
   assign cmp_req = '{a: cur_stamp, b: lru_stamp_ff};
   dscl_cmp u_cmp (.req(cmp_req), .less(cmp_less));

   // Block sweep view.
   logic [SlotW-1:0] own;
   logic [TagW-1:0]  own_tag;
   logic             hitme, do_wb;
   logic [31:0]      wa;
   row_type          vrow_next;
   always_comb begin
      own     = vrow_ff.blk_slot[bi_ff];
      own_tag = vrow_ff.tag_value[own];
      hitme   = ((own == a_slot) && (own_tag != a_tag)) || (bi_ff == a_blk);
      do_wb   = hitme && vrow_ff.blk_live[bi_ff] && vrow_ff.blk_mod[bi_ff];
      wa      = 32'(own_tag);
      wa      = (wa << SlotB) | 32'(own);
      wa      = (wa << SetB) | 32'(a_set);
      wa      = (wa << BlkB) | 32'(bi_ff);
      wa      = wa << OffW;
      // Drop a displaced live block from the victim copy.
      vrow_next = vrow_ff;
      if (hitme && vrow_ff.blk_live[bi_ff]) begin
         vrow_next.blk_live[bi_ff] = 1'b0;
         vrow_next.blk_mod[bi_ff]  = 1'b0;
         vrow_next.blk_slot[bi_ff] = '0;
      end
   end

   logic out_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Single write port: restamp a hit sector, or install the refilled victim.
   logic           wr_en;
   logic [SxW-1:0] wr_sx;
   row_type        wr_row;
   logic [31:0]    wr_stamp;
   always_comb begin
      wr_en    = 1'b0;
      wr_sx    = cur_sx;
      wr_row   = cur_row;
      wr_stamp = counter_ff;
      if (state_ff == ST_SCAN && hitcond) begin
         wr_en = 1'b1;
         if (wr_ff) wr_row.blk_mod[a_blk] = 1'b1;
      end else if (state_ff == ST_FILL && out_free) begin
         wr_en  = 1'b1;
         wr_sx  = sx_of(a_set, victim_ff);
         wr_row = vrow_ff;
         wr_row.blk_live[a_blk]   = 1'b1;
         wr_row.blk_mod[a_blk]    = wr_ff;
         wr_row.blk_slot[a_blk]   = a_slot;
         wr_row.tag_live[a_slot]  = 1'b1;
         wr_row.tag_value[a_slot] = a_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[wr_sx]  <= wr_row;
         stamp_ff[wr_sx] <= wr_stamp;
      end
      rd_row_ff   <= rows_ff[rd_sx];
      rd_stamp_ff <= stamp_ff[rd_sx];
   end

   // Next state and sequencing.
   always_comb begin
      state_in      = state_ff;
      counter_in    = counter_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_READ;
         ST_READ:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (hitcond) counter_in = counter_ff + 32'd1;
            if (sec_ff == '0) state_in = ST_EMIT;
            else state_in = ST_READ;
         end
         ST_EMIT: begin
            // Hit: emit single result. Miss: fetch victim row.
            if (found_ff) begin
               if (out_free) begin
                  state_in      = ST_IDLE;
                  rsp_tvalid_in = 1'b1;
               end
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:   state_in = ST_BLOCKS;
         ST_BLOCKS: begin
            if (!do_wb || out_free) begin
               if (do_wb) rsp_tvalid_in = 1'b1;
               if (bi_ff == BlkW'(BlocksPerSector - 1)) state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               counter_in    = counter_ff + 32'd1;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         counter_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         row_ok_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         counter_ff    <= counter_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rd_ok_ff      <= row_ok_ff[rd_sx];
         if (wr_en) row_ok_ff[wr_sx] <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  wr_ff        <= req_tdata[0];
                  addr_ff      <= req_tdata[32:1];
                  sec_ff       <= SecW'(SectorsPerSet - 1);
                  found_ff     <= 1'b0;
                  ib_ff        <= 1'b0;
                  it_ff        <= 1'b0;
                  lru_ff       <= SecW'(SectorsPerSet - 1);
                  lru_stamp_ff <= '1;
               end
            end
            ST_SCAN: begin
               if (hitcond) found_ff <= 1'b1;
               // First compared sector is the top one; seed with it.
               if (sec_ff == SecW'(SectorsPerSet - 1) || cmp_less) begin
                  lru_ff       <= sec_ff;
                  lru_stamp_ff <= cur_stamp;
               end
               if (tmatch && !blive) begin
                  vb_ff <= sec_ff;
                  ib_ff <= 1'b1;
               end
               if (!cur_row.tag_live[a_slot] && !it_ff) begin
                  vt_ff <= sec_ff;
                  it_ff <= 1'b1;
               end
               if (sec_ff != '0) sec_ff <= sec_ff - SecW'(1);
            end
            ST_EMIT: begin
               if (found_ff) begin
                  if (out_free) begin
                     okind_ff   <= KIND_HIT;
                     oaddr_ff   <= '0;
                     ohit_ff    <= 1'b1;
                     olast_ff   <= 1'b1;
                  end
               end else begin
                  victim_ff <= victim_sel;
               end
            end
            ST_LOAD: begin
               vrow_ff <= cur_row;
               bi_ff   <= '0;
            end
            ST_BLOCKS: begin
               if (!do_wb || out_free) begin
                  if (do_wb) begin
                     okind_ff   <= KIND_WB;
                     oaddr_ff   <= wa;
                     ohit_ff    <= 1'b0;
                     olast_ff   <= 1'b0;
                  end
                  vrow_ff <= vrow_next;
                  if (bi_ff != BlkW'(BlocksPerSector - 1)) bi_ff <= bi_ff + BlkW'(1);
               end
            end
            ST_FILL: begin
               if (out_free) begin
                  okind_ff   <= KIND_FILL;
                  oaddr_ff   <= addr_ff;
                  ohit_ff    <= 1'b0;
                  olast_ff   <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tdata = {5'd0, ohit_ff, oaddr_ff, okind_ff};
   assign rsp_tlast = olast_ff;

`ifndef SYNTHESIS
   // A hit result is always the last of its access.
   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ohit_ff |-> olast_ff) else $error("hit not last");
   // No new access while a lookup is in flight.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready) else $error("ready while busy");
   // A fill always terminates the access.
   a_fill_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && okind_ff == KIND_FILL |-> olast_ff) else $error("fill not last");
`endif
endmodule
`default_nettype wire

/* tb/sv/decoupled_sectored_cache_lookup_tb.sv */
// Self-checking testbench for decoupled_sectored_cache_lookup: predicts hits,
// writebacks and fills for each read/write transaction and checks each result.
// Depends on dscl_pkg and the block's RTL.
`default_nettype none
module decoupled_sectored_cache_lookup_tb;
   import dscl_pkg::*;

   localparam bit CMD_READ  = 1'b0;
   localparam bit CMD_WRITE = 1'b1;
   localparam int NTagSlots = NSect * TagsPerSector;
   localparam int NBlocks   = NSect * BlocksPerSector;

   // One expected result transaction.
   typedef struct {
      kind_type    kind;
      logic [31:0] mem_address;
      logic        hit;
      logic        last;
   } dir_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [0] cmd, [32:1] address, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [1:0] kind, [33:2] mem_address, [34] hit
   logic        rsp_tlast;

   // Shadow copy of the directory, tags held at full 32-bit width.
   logic [31:0] shadow_tag[NTagSlots];
   logic        shadow_tag_live[NTagSlots];
   logic        shadow_blk_live[NBlocks];
   logic        shadow_blk_dirty[NBlocks];
   int unsigned shadow_blk_slot[NBlocks];
   logic [31:0] shadow_stamp[NSect];
   logic [31:0] shadow_clock_stamp;

   dir_result_type pending_results[$];
   int  mismatches   = 0;
   int  accesses     = 0;
   int  hits_seen    = 0;
   int  writebacks   = 0;
   int  fills_seen   = 0;
   bit  idling_on    = 1'b1;

   decoupled_sectored_cache_lookup u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Build an address from its directory fields.
   function automatic logic [31:0] pack_address(int unsigned tag, int unsigned slot,
                                                int unsigned set, int unsigned blk,
                                                int unsigned off);
      logic [31:0] a;
      a = tag * TagsPerSector + slot;
      a = a * NumSets + set;
      a = a * BlocksPerSector + blk;
      return a * BlockBytes + off;
   endfunction

   // Advance the shadow directory by one access and queue its results.
   task automatic predict_lookup(input bit wr, input logic [31:0] addr);
      int unsigned b, blk, set, slot, sx, ti, bi, own, oti, sec;
      logic [31:0] tag, wb_addr;
      bit found, blk_gap, slot_free, tmatch, displaced;
      int lru, gap_sec, free_sec, victim;
      dir_result_type r;
      b       = addr / BlockBytes;
      blk     = b % BlocksPerSector;
      set     = (b / BlocksPerSector) % NumSets;
      slot    = (b / (BlocksPerSector * NumSets)) % TagsPerSector;
      tag     = b / (BlocksPerSector * NumSets * TagsPerSector);
      found   = 0;
      blk_gap = 0;
      slot_free = 0;
      lru     = SectorsPerSet - 1;
      gap_sec = 0;
      free_sec = 0;
      // Scan sectors from the top: restamp every hit, track the victim candidates.
      for (int s = SectorsPerSet - 1; s >= 0; s--) begin
         sx = set * SectorsPerSet + s;
         ti = sx * TagsPerSector + slot;
         bi = sx * BlocksPerSector + blk;
         tmatch = shadow_tag_live[ti] && shadow_tag[ti] == tag;
         if (tmatch && shadow_blk_live[bi] && shadow_blk_slot[bi] == slot) begin
            found = 1;
            shadow_stamp[sx] = shadow_clock_stamp;
            shadow_clock_stamp++;
            if (wr) shadow_blk_dirty[bi] = 1;
         end
         if (shadow_stamp[sx] < shadow_stamp[set * SectorsPerSet + lru]) lru = s;
         if (tmatch && !shadow_blk_live[bi]) begin
            gap_sec = s;
            blk_gap = 1;
         end
         if (!shadow_tag_live[ti] && !slot_free) begin
            free_sec = s;
            slot_free = 1;
         end
      end
      if (found) begin
         r = '{KIND_HIT, 32'd0, 1'b1, 1'b1};
         pending_results.push_back(r);
         return;
      end
      victim = blk_gap ? gap_sec : (slot_free ? free_sec : lru);
      sec = set * SectorsPerSet + victim;
      // Sweep the victim's blocks in order, writing back the dirty displaced ones.
      for (int i = 0; i < BlocksPerSector; i++) begin
         bi  = sec * BlocksPerSector + i;
         own = shadow_blk_slot[bi] % TagsPerSector;
         oti = sec * TagsPerSector + own;
         displaced = (own == slot && shadow_tag[oti] != tag) || i == blk;
         if (displaced && shadow_blk_live[bi]) begin
            if (shadow_blk_dirty[bi]) begin
               wb_addr = shadow_tag[oti] * TagsPerSector + own;
               wb_addr = wb_addr * NumSets + set;
               wb_addr = wb_addr * BlocksPerSector + i;
               wb_addr = wb_addr * BlockBytes;
               r = '{KIND_WB, wb_addr, 1'b0, 1'b0};
               pending_results.push_back(r);
            end
            shadow_blk_slot[bi]  = 0;
            shadow_blk_live[bi]  = 0;
            shadow_blk_dirty[bi] = 0;
         end
      end
      bi = sec * BlocksPerSector + blk;
      ti = sec * TagsPerSector + slot;
      shadow_blk_live[bi]  = 1;
      shadow_blk_dirty[bi] = wr;
      shadow_blk_slot[bi]  = slot;
      shadow_tag_live[ti]  = 1;
      shadow_tag[ti]       = tag;
      shadow_stamp[sec]    = shadow_clock_stamp;
      shadow_clock_stamp++;
      r = '{KIND_FILL, addr, 1'b0, 1'b1};
      pending_results.push_back(r);
   endtask

   // Send one access, with an optional idle burst first; predict on acceptance.
   task automatic send_access(input bit wr, input logic [31:0] addr);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 40'({$urandom, $urandom});
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, addr, wr};
      do @(posedge clock); while (!req_tready);
      predict_lookup(wr, addr);
      accesses++;
   endtask

   // Random access into a handful of tags and sets so sectors collide often.
   task automatic send_clustered_access();
      send_access(1'($urandom_range(0, 1)),
                  pack_address($urandom_range(0, 5), $urandom_range(0, TagsPerSector - 1),
                               $urandom_range(0, 2), $urandom_range(0, BlocksPerSector - 1),
                               $urandom_range(0, BlockBytes - 1)));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Corners: address extremes, hit on read and write, LRU eviction with
   // dirty writebacks, tag present with block missing, and the other tag slot.
   task automatic test_directed();
      send_access(CMD_READ, 32'h0000_0000);
      send_access(CMD_READ, 32'h0000_0000);
      send_access(CMD_WRITE, 32'h0000_001F);
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      send_access(CMD_READ, 32'hFFFF_FFE0);
      for (int t = 1; t <= 4; t++) begin
         send_access(CMD_WRITE, pack_address(t, 0, 0, 1, 0));
         send_access(CMD_WRITE, pack_address(t, 0, 0, 3, 4));
      end
      send_access(CMD_READ, pack_address(9, 0, 0, 1, 0));
      send_access(CMD_WRITE, pack_address(9, 0, 0, 2, 0));
      send_access(CMD_WRITE, pack_address(9, 1, 0, 2, 0));
      send_access(CMD_READ, pack_address(10, 1, 0, 2, 0));
      send_access(CMD_READ, pack_address(0, 0, 0, 0, 0));
      send_access(CMD_WRITE, pack_address(9, 0, 0, 2, 8));
      send_access(CMD_READ, 32'h8000_0000);
   endtask

   // Hold off the sender until every expected result has come back, then send three writes.
   task automatic test_drain_pause();
      wait_for_drain();
      repeat (3) send_access(CMD_WRITE, pack_address(2, 1, 5, 0, 0));
   endtask

   task automatic test_random_clustered(input int count);
      repeat (count) send_clustered_access();
   endtask

   // Full-range noise, so every address bit toggles.
   task automatic test_random_noise(input int count);
      repeat (count) send_access(1'($urandom_range(0, 1)), $urandom);
   endtask

   // Receiver: stall in random bursts while idling is enabled.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      dir_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: tdata %h last %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] != want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tdata[1:0]);
               mismatches++;
            end
            if (rsp_tdata[33:2] != want.mem_address) begin
               $error("mem_address: expected %h, got %h", want.mem_address, rsp_tdata[33:2]);
               mismatches++;
            end
            if (rsp_tdata[34] != want.hit) begin
               $error("hit: expected %b, got %b", want.hit, rsp_tdata[34]);
               mismatches++;
            end
            if (rsp_tlast != want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               mismatches++;
            end
            case (want.kind)
               KIND_HIT: hits_seen++;
               KIND_WB:  writebacks++;
               default:  fills_seen++;
            endcase
         end
      end
   end

   initial begin
      for (int i = 0; i < NTagSlots; i++) begin
         shadow_tag[i] = '0;
         shadow_tag_live[i] = 1'b0;
      end
      for (int i = 0; i < NBlocks; i++) begin
         shadow_blk_live[i] = 1'b0;
         shadow_blk_dirty[i] = 1'b0;
         shadow_blk_slot[i] = 0;
      end
      for (int i = 0; i < NSect; i++) shadow_stamp[i] = '0;
      shadow_clock_stamp = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_clustered(120);
      test_drain_pause();
      test_random_noise(40);
      test_random_clustered(80);
      // Last stretch runs at full rate on both sides.
      idling_on = 1'b0;
      test_random_clustered(40);
      @(posedge clock);
      wait_for_drain();
      repeat (30) @(posedge clock);
      $display("covered %0d accesses: %0d hits, %0d writebacks, %0d fills",
               accesses, hits_seen, writebacks, fills_seen);
      if (mismatches == 0)
         $display("decoupled_sectored_cache_lookup regression: pass");
      else
         $display("decoupled_sectored_cache_lookup regression: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #8000000;
      $display("decoupled_sectored_cache_lookup regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
